// ===== rtl/ubrc_pkg.sv =====
// Shared types, constants and register codes for the unaligned bit range copy block.
`default_nettype none

package ubrc_pkg;

   localparam int MAX_COPY_BITS = 65536;
   localparam int REM_W         = $clog2(MAX_COPY_BITS + 1);
   localparam int IDX_W         = 14;
   localparam int LEN_W         = 17;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 17;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_BIT_OFFSET = 3'd0,
      CSR_DST_BIT_OFFSET = 3'd1,
      CSR_BIT_LENGTH     = 3'd2,
      CSR_OLD_HEAD_BYTE  = 3'd3,
      CSR_OLD_TAIL_BYTE  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       first_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]       dst_byte;
      logic [IDX_W-1:0] dst_index;
      logic             last_out;
   } rsp_type;

   typedef struct packed {
      logic [2:0]       src_bit_offset;
      logic [2:0]       dst_bit_offset;
      logic [LEN_W-1:0] bit_length;
      logic [7:0]       old_head_byte;
      logic [7:0]       old_tail_byte;
   } cfg_type;

   // Results produced by one item, in order; res1 is used only when count is two.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } push_type;

endpackage

`default_nettype wire

// ===== rtl/ubrc_engine.sv =====
// Copy engine: bit accumulator state and the funnel shift and merge for one source byte.
`default_nettype none

module ubrc_engine import ubrc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output push_type     push
);

   logic [15:0]      acc_ff,    acc_in;
   logic [3:0]       abits_ff,  abits_in;
   logic [REM_W-1:0] rem_ff,    rem_in;
   logic [IDX_W-1:0] idx_ff,    idx_in;
   logic             active_ff, active_in;

   function automatic logic [7:0] low_mask8(input logic [3:0] n);
      low_mask8 = (n >= 4'd8) ? 8'hFF : 8'((16'd1 << n) - 16'd1);
   endfunction

   logic [REM_W-1:0] len;
   logic [15:0]      acc0, acc1, acc2;
   logic [3:0]       abits0, abits1, abits2, room, take;
   logic [REM_W-1:0] rem0, rem1;
   logic [IDX_W-1:0] idx0, idx2;
   logic [2:0]       skip;
   logic [7:0]       fld, tmask, old_byte;
   logic             run, emit_full, emit_tail;

   always_comb begin
      if (int'(cfg.bit_length) > MAX_COPY_BITS) begin
         len = REM_W'(MAX_COPY_BITS);
      end else begin
         len = REM_W'(cfg.bit_length);
      end

      // Starting state for this byte: a first byte loads fresh copy state.
      if (item.first_byte) begin
         run    = (len != '0);
         acc0   = {8'd0, cfg.old_head_byte & low_mask8({1'b0, cfg.dst_bit_offset})};
         abits0 = {1'b0, cfg.dst_bit_offset};
         rem0   = len;
         idx0   = '0;
         skip   = cfg.src_bit_offset;
      end else begin
         run    = active_ff;
         acc0   = acc_ff;
         abits0 = abits_ff;
         rem0   = rem_ff;
         idx0   = idx_ff;
         skip   = 3'd0;
      end

      room = 4'd8 - {1'b0, skip};
      take = (rem0 < REM_W'(room)) ? rem0[3:0] : room;
      fld  = (item.src_byte >> skip) & low_mask8(take);

      acc1   = acc0 | (16'(fld) << abits0);
      abits1 = abits0 + take;
      rem1   = rem0 - REM_W'(take);

      emit_full = abits1 >= 4'd8;
      acc2      = emit_full ? (acc1 >> 8) : acc1;
      abits2    = emit_full ? (abits1 - 4'd8) : abits1;
      idx2      = emit_full ? (idx0 + IDX_W'(1)) : idx0;

      emit_tail = (rem1 == '0) && (abits2 != 4'd0);
      tmask     = low_mask8(abits2);
      old_byte  = (idx2 == '0) ? cfg.old_head_byte : cfg.old_tail_byte;

      push = '0;
      if (run) begin
         if (emit_full) begin
            push.res0.dst_byte  = acc1[7:0];
            push.res0.dst_index = idx0;
            push.res0.last_out  = (rem1 == '0) && (abits1 == 4'd8);
            push.res1.dst_byte  = (acc2[7:0] & tmask) | (old_byte & ~tmask);
            push.res1.dst_index = idx2;
            push.res1.last_out  = 1'b1;
            push.count          = emit_tail ? 2'd2 : 2'd1;
         end else if (emit_tail) begin
            push.res0.dst_byte  = (acc2[7:0] & tmask) | (old_byte & ~tmask);
            push.res0.dst_index = idx2;
            push.res0.last_out  = 1'b1;
            push.count          = 2'd1;
         end
      end

      acc_in    = acc_ff;
      abits_in  = abits_ff;
      rem_in    = rem_ff;
      idx_in    = idx_ff;
      active_in = active_ff;
      if (step) begin
         if (item.first_byte && !run) begin
            acc_in    = '0;
            abits_in  = '0;
            rem_in    = '0;
            idx_in    = '0;
            active_in = 1'b0;
         end else if (run) begin
            if (rem1 == '0) begin
               acc_in    = '0;
               abits_in  = '0;
               active_in = 1'b0;
            end else begin
               acc_in    = acc2;
               abits_in  = abits2;
               active_in = 1'b1;
            end
            rem_in = rem1;
            idx_in = emit_tail ? (idx2 + IDX_W'(1)) : idx2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         abits_ff  <= '0;
         rem_ff    <= '0;
         idx_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         abits_ff  <= abits_in;
         rem_ff    <= rem_in;
         idx_ff    <= idx_in;
         active_ff <= active_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ubrc_out_queue.sv =====
// Four-entry result queue that takes up to two results a cycle and gives one when the output is not stalled.
`default_nettype none

module ubrc_out_queue import ubrc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   output logic          room,
   output logic          rsp_valid,
   input  wire logic     rsp_stall,
   output rsp_type       rsp_payload
);

   rsp_type    entry_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff,  count_in;
   logic       pop;

   assign room        = count_ff <= 3'd2;
   assign rsp_valid   = count_ff != 3'd0;
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + push.count;
      rd_ptr_in = pop ? (rd_ptr_ff + 2'd1) : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push.count} - {2'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_ff + 2'd1] <= push.res1;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/unaligned_bit_range_copy.sv =====
// Top level of the unaligned bit range copy block: registers, input stage and result queue.
//
//   Channel | Direction | Handshake           | Payload
//   req     | in        | req_valid/req_stall | req_type: src_byte, first_byte
//   rsp     | out       | rsp_valid/rsp_stall | rsp_type: dst_byte, dst_index, last_out
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// Each source byte passes through an input register and, once the queue has room, through
// the engine, which shifts it into the bit accumulator and writes zero, one or two merged
// destination bytes into a four-entry result queue. One byte is taken every cycle while
// the queue holds at most two results; the output port drains one result per unstalled cycle.
// Reset is synchronous and active high and empties the input stage and the queue.
// A stall on the result side fills the queue and then stalls the input side.
`default_nettype none

module unaligned_bit_range_copy import ubrc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_payload,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   // Configuration registers. The user must change these only while the block is idle; the
   // block itself does not enforce this, and the engine reads them directly.
   cfg_type cfg_ff, cfg_in;

   // Input register that holds one source byte in front of the engine.
   req_type in_ff, in_in;
   logic    in_valid_ff, in_valid_in;

   logic     room;
   logic     step;
   push_type push;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SRC_BIT_OFFSET: cfg_in.src_bit_offset = csr_data[2:0];
            CSR_DST_BIT_OFFSET: cfg_in.dst_bit_offset = csr_data[2:0];
            CSR_BIT_LENGTH:     cfg_in.bit_length     = csr_data[LEN_W-1:0];
            CSR_OLD_HEAD_BYTE:  cfg_in.old_head_byte  = csr_data[7:0];
            CSR_OLD_TAIL_BYTE:  cfg_in.old_tail_byte  = csr_data[7:0];
            default:            cfg_in                = cfg_ff;
         endcase
      end
   end

   // The held byte moves into the engine only when the queue has room for the
   // two results it might produce.
   assign step      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff && !step;
      if (req_valid && !req_stall) begin
         in_in       = req_payload;
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         in_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
      end
      in_ff <= in_in;
   end

   ubrc_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_ff),
      .cfg   (cfg_ff),
      .push  (push)
   );

   ubrc_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (step ? push : '0),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
